[design/tsom_pkg.sv]
package tsom_pkg;

    // Field widths
    localparam int KIND_W    = 2;
    localparam int TS_W      = 63;
    localparam int CORR_W    = 32;
    localparam int OFS_W     = 64;
    localparam int TOL_W     = 32;
    localparam int SRC_W     = 2;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 64;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam logic [TOL_W-1:0] TOL_RESET = 32'd1000000;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_SENSOR    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REFERENCE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART   = 2'd2;

    // Where a match was found
    localparam logic [SRC_W-1:0] SRC_NONE      = 2'd0;
    localparam logic [SRC_W-1:0] SRC_SENSOR    = 2'd1;
    localparam logic [SRC_W-1:0] SRC_REFERENCE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_OFFSET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOLERANCE = 2'd1;

endpackage

[design/tsom_match_unit.sv]
module tsom_match_unit #(
    parameter int TAG_W = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      flush,
    input  logic                      in_valid,
    input  logic [TAG_W-1:0]          in_tag,
    input  logic [tsom_pkg::TS_W-1:0] in_a,
    input  logic [tsom_pkg::TS_W-1:0] in_b,
    input  logic [tsom_pkg::OFS_W-1:0] cur_offset,
    input  logic [tsom_pkg::TOL_W-1:0] tolerance,
    output logic                      busy,
    output logic                      out_valid,
    output logic [TAG_W-1:0]          out_tag,
    output logic [tsom_pkg::OFS_W-1:0] out_diff,
    output logic                      out_hit
);
    import tsom_pkg::*;

    // d = a - b ; res = d - offset ; |res| <= tolerance
    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    logic [TAG_W-1:0] t1_reg, t2_reg, t3_reg, t4_reg;
    logic [OFS_W-1:0] d1_reg, d2_reg, d3_reg, d4_reg;
    logic [OFS_W:0]   res_reg;
    logic [OFS_W:0]   mag_reg;
    logic             hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || flush) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        t1_reg  <= in_tag;
        d1_reg  <= {1'b0, in_a} - {1'b0, in_b};
        t2_reg  <= t1_reg;
        d2_reg  <= d1_reg;
        res_reg <= {d1_reg[OFS_W-1], d1_reg} - {cur_offset[OFS_W-1], cur_offset};
        t3_reg  <= t2_reg;
        d3_reg  <= d2_reg;
        mag_reg <= res_reg[OFS_W] ? ((OFS_W+1)'(0) - res_reg) : res_reg;
        t4_reg  <= t3_reg;
        d4_reg  <= d3_reg;
        hit_reg <= (mag_reg <= (OFS_W+1)'(tolerance));
    end

    assign busy      = v1_reg | v2_reg | v3_reg | v4_reg;
    assign out_valid = v4_reg;
    assign out_tag   = t4_reg;
    assign out_diff  = d4_reg;
    assign out_hit   = hit_reg;

endmodule

[design/timestamp_offset_matcher.sv]
// Matches sensor timestamps against reference timestamps to track their offset. One word is
// taken at a time: s_ready is high only while the block is idle. Sensor, restart and unused
// words pass from acceptance through a push state to a done state, which presents their result
// word and returns to idle. A reference word with a non-empty sensor queue scans the
// sensor queue newest first and, failing a match, the reference queue; each scan issues one
// queue read per cycle into a difference/tolerance pipeline until a hit or the queue's end. A
// result word waits in the output register while the next word is taken. Queues are circular
// buffers in RAM; a full queue overwrites its oldest entry and flags it. Registers are to be
// written through the cfg port only while the block is idle; the block itself does not enforce
// this. Register 0 is the initial offset, 1 the match tolerance.
module timestamp_offset_matcher #(
    parameter int QUEUE_DEPTH = tsom_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [tsom_pkg::KIND_W-1:0]        s_kind,
    input  logic [tsom_pkg::TS_W-1:0]          s_timestamp,
    input  logic [tsom_pkg::CORR_W-1:0]        s_correction,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [tsom_pkg::OFS_W-1:0]  m_offset,
    output logic                               m_updated,
    output logic [tsom_pkg::SRC_W-1:0]         m_match_source,
    output logic                               m_dropped,
    output logic [tsom_pkg::CNT_W-1:0]         m_sensor_count,
    output logic [tsom_pkg::CNT_W-1:0]         m_reference_count,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tsom_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tsom_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import tsom_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PUSH   = 5'b00010,
        ST_SCAN_S = 5'b00100,
        ST_SCAN_R = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] x);
        logic [SUM_W-1:0] y;
        y = (x >= SUM_W'(QUEUE_DEPTH)) ? (x - SUM_W'(QUEUE_DEPTH)) : x;
        return y[PTR_W-1:0];
    endfunction

    state_t            state_reg, state_next;

    logic [KIND_W-1:0] kind_reg;
    logic [TS_W-1:0]   ts_reg;
    logic [CORR_W-1:0] corr_reg;

    logic [PTR_W-1:0]  s_head_reg, r_head_reg;
    logic [FILL_W-1:0] s_fill_reg, r_fill_reg;
    logic [OFS_W-1:0]  offset_reg;
    logic [OFS_W-1:0]  init_offset_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [TS_W-1:0]   newest_s_reg;

    logic [FILL_W-1:0] remain_reg;
    logic              rd_valid_reg;
    logic [PTR_W-1:0]  rd_pos_reg;

    logic              dropped_reg;
    logic [SRC_W-1:0]  source_reg;

    logic                    m_valid_reg;
    logic signed [OFS_W-1:0] m_offset_reg;
    logic                    m_updated_reg;
    logic [SRC_W-1:0]        m_source_reg;
    logic                    m_dropped_reg;
    logic [CNT_W-1:0]        m_scount_reg, m_rcount_reg;

    logic [TS_W-1:0] s_mem [QUEUE_DEPTH];
    logic [TS_W-1:0] r_mem [QUEUE_DEPTH];
    logic [TS_W-1:0] s_rdata_reg, r_rdata_reg;

    // datapath helpers
    logic [OFS_W-1:0]  corr_diff;
    logic [TS_W-1:0]   sensor_value;
    logic              s_full, r_full;
    logic [PTR_W-1:0]  s_waddr, r_waddr;
    logic [PTR_W-1:0]  s_head_inc, r_head_inc;
    logic              scanning, issue;
    logic [FILL_W-1:0] remain_dec;
    logic [PTR_W-1:0]  rd_addr;
    logic              out_free;

    // match unit
    logic [TS_W-1:0]   mu_a, mu_b;
    logic              mu_busy, mu_valid, mu_hit;
    logic [PTR_W-1:0]  mu_pos;
    logic [OFS_W-1:0]  mu_diff;
    logic              hit_now, scan_miss;
    logic [SUM_W-1:0]  cut;

    assign corr_diff    = {1'b0, ts_reg} - OFS_W'(corr_reg);
    assign sensor_value = corr_diff[OFS_W-1] ? '0 : corr_diff[TS_W-1:0];

    assign s_full     = (s_fill_reg == FILL_W'(QUEUE_DEPTH));
    assign r_full     = (r_fill_reg == FILL_W'(QUEUE_DEPTH));
    assign s_waddr    = wrap(SUM_W'(s_head_reg) + SUM_W'(s_fill_reg));
    assign r_waddr    = wrap(SUM_W'(r_head_reg) + SUM_W'(r_fill_reg));
    assign s_head_inc = wrap(SUM_W'(s_head_reg) + SUM_W'(1));
    assign r_head_inc = wrap(SUM_W'(r_head_reg) + SUM_W'(1));

    assign scanning   = (state_reg == ST_SCAN_S) || (state_reg == ST_SCAN_R);
    assign hit_now    = scanning && mu_valid && mu_hit;
    assign issue      = scanning && (remain_reg != '0) && !hit_now;
    assign remain_dec = remain_reg - FILL_W'(1);
    assign rd_addr    = wrap(SUM_W'((state_reg == ST_SCAN_S) ? s_head_reg : r_head_reg)
                             + SUM_W'(remain_dec[PTR_W-1:0]));
    assign scan_miss  = (remain_reg == '0) && !rd_valid_reg && !mu_busy;
    assign cut        = SUM_W'(mu_pos) + SUM_W'(1);
    assign out_free   = !m_valid_reg || m_ready;

    assign mu_a = (state_reg == ST_SCAN_S) ? ts_reg : r_rdata_reg;
    assign mu_b = (state_reg == ST_SCAN_S) ? s_rdata_reg : newest_s_reg;

    tsom_match_unit #(
        .TAG_W(PTR_W)
    ) u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .flush     (hit_now),
        .in_valid  (rd_valid_reg),
        .in_tag    (rd_pos_reg),
        .in_a      (mu_a),
        .in_b      (mu_b),
        .cur_offset(offset_reg),
        .tolerance (tol_reg),
        .busy      (mu_busy),
        .out_valid (mu_valid),
        .out_tag   (mu_pos),
        .out_diff  (mu_diff),
        .out_hit   (mu_hit)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (kind_reg == KIND_REFERENCE && s_fill_reg != '0) state_next = ST_SCAN_S;
                else state_next = ST_DONE;
            end
            ST_SCAN_S: begin
                if (hit_now) state_next = ST_DONE;
                else if (scan_miss) state_next = ST_SCAN_R;
            end
            ST_SCAN_R: begin
                if (hit_now || scan_miss) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            s_head_reg      <= '0;
            r_head_reg      <= '0;
            s_fill_reg      <= '0;
            r_fill_reg      <= '0;
            offset_reg      <= '0;
            init_offset_reg <= '0;
            tol_reg         <= TOL_RESET;
            remain_reg      <= '0;
            rd_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            if (issue) remain_reg <= remain_dec;

            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_INITIAL_OFFSET:  init_offset_reg <= cfg_data;
                    REG_MATCH_TOLERANCE: tol_reg         <= cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_PUSH: begin
                    case (kind_reg)
                        KIND_SENSOR: begin
                            if (s_full) s_head_reg <= s_head_inc;
                            else s_fill_reg <= s_fill_reg + FILL_W'(1);
                        end
                        KIND_REFERENCE: begin
                            if (r_full) r_head_reg <= r_head_inc;
                            else r_fill_reg <= r_fill_reg + FILL_W'(1);
                            remain_reg <= s_fill_reg;
                        end
                        KIND_RESTART: begin
                            s_fill_reg <= '0;
                            r_fill_reg <= '0;
                            offset_reg <= init_offset_reg;
                        end
                        default: ;
                    endcase
                end
                ST_SCAN_S: begin
                    if (hit_now) begin
                        offset_reg <= mu_diff;
                        s_head_reg <= wrap(SUM_W'(s_head_reg) + cut);
                        s_fill_reg <= s_fill_reg - cut[FILL_W-1:0];
                        r_fill_reg <= '0;
                    end else if (scan_miss) begin
                        remain_reg <= r_fill_reg;
                    end
                end
                ST_SCAN_R: begin
                    if (hit_now) begin
                        offset_reg <= mu_diff;
                        r_head_reg <= wrap(SUM_W'(r_head_reg) + cut);
                        r_fill_reg <= r_fill_reg - cut[FILL_W-1:0];
                        s_fill_reg <= '0;
                    end
                end
                default: ;
            endcase

            if (state_reg == ST_DONE && out_free) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // payload and queue memories
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            kind_reg <= s_kind;
            ts_reg   <= s_timestamp;
            corr_reg <= s_correction;
        end

        if (state_reg == ST_PUSH) begin
            source_reg  <= SRC_NONE;
            if (kind_reg == KIND_SENSOR) begin
                s_mem[s_waddr] <= sensor_value;
                newest_s_reg   <= sensor_value;
                dropped_reg    <= s_full;
            end else if (kind_reg == KIND_REFERENCE) begin
                r_mem[r_waddr] <= ts_reg;
                dropped_reg    <= r_full;
            end else begin
                dropped_reg    <= 1'b0;
            end
        end

        if (hit_now) source_reg <= (state_reg == ST_SCAN_S) ? SRC_SENSOR : SRC_REFERENCE;

        if (issue) begin
            rd_pos_reg <= remain_dec[PTR_W-1:0];
            if (state_reg == ST_SCAN_S) s_rdata_reg <= s_mem[rd_addr];
            else r_rdata_reg <= r_mem[rd_addr];
        end

        if (state_reg == ST_DONE && out_free) begin
            m_offset_reg  <= offset_reg;
            m_updated_reg <= (source_reg != SRC_NONE);
            m_source_reg  <= source_reg;
            m_dropped_reg <= dropped_reg;
            m_scount_reg  <= CNT_W'(s_fill_reg);
            m_rcount_reg  <= CNT_W'(r_fill_reg);
        end
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign cfg_ready         = 1'b1;
    assign m_valid           = m_valid_reg;
    assign m_offset          = m_offset_reg;
    assign m_updated         = m_updated_reg;
    assign m_match_source    = m_source_reg;
    assign m_dropped         = m_dropped_reg;
    assign m_sensor_count    = m_scount_reg;
    assign m_reference_count = m_rcount_reg;

endmodule
